### hdl/fcds_pkg.sv
// ----------------------------------------------------------------------------
// fcds_pkg
// shared types and constants for the fraction common-denominator unit
// ----------------------------------------------------------------------------
package fcds_pkg;

    localparam int IN_WIDTH_DEF = 16;
    localparam int OUT_W        = 32;
    localparam int SUM_W        = 33;
    localparam int DIV_STEPS    = SUM_W;
    localparam int CNT_W        = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_JOB,
        S_GCD_GO,
        S_GCD_WAIT,
        S_GCD_CHK,
        S_P_GO,
        S_P_WAIT,
        S_Q_GO,
        S_Q_WAIT,
        S_WRITE,
        S_MUL,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_JOB,
        OP_GCD_GO,
        OP_GCD_WAIT,
        OP_P_GO,
        OP_P_WAIT,
        OP_Q_GO,
        OP_Q_WAIT,
        OP_WRITE,
        OP_MUL
    } t_op;

    // which pair is being reduced
    typedef enum logic [2:0] {
        J_A,
        J_B,
        J_L,
        J_S,
        J_Q
    } t_job;

    typedef struct packed {
        t_op  op;
        t_job job;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic gy_zero;
        logic sb_zero;
    } t_sts;

endpackage

### hdl/fcds_div.sv
// ----------------------------------------------------------------------------
// fcds_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fcds_div
    import fcds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [OUT_W-1:0]  i_divisor,
    output logic [SUM_W-1:0]  o_quo,
    output logic [OUT_W-1:0]  o_rem,
    output logic              o_done
);

    logic [SUM_W-1:0] r_quo;
    logic [OUT_W-1:0] r_rem;
    logic [OUT_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SUM_W-1:0] w_trial;
    logic             w_ge;
    logic [SUM_W-1:0] w_diff;

    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[OUT_W-1:0] : w_trial[OUT_W-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

### hdl/fcds_dp.sv
// ----------------------------------------------------------------------------
// fcds_dp
// operand registers, gcd reduction loop and result registers
// ----------------------------------------------------------------------------
module fcds_dp
    import fcds_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [IN_WIDTH-1:0] i_num_a,
    input  logic [IN_WIDTH-1:0] i_den_a,
    input  logic [IN_WIDTH-1:0] i_num_b,
    input  logic [IN_WIDTH-1:0] i_den_b,
    output logic [OUT_W-1:0]    o_scaled_num_a,
    output logic [OUT_W-1:0]    o_scaled_num_b,
    output logic [OUT_W-1:0]    o_common_den,
    output logic [SUM_W-1:0]    o_sum_num,
    output logic [OUT_W-1:0]    o_sum_den,
    output logic [OUT_W-1:0]    o_quot_num,
    output logic [OUT_W-1:0]    o_quot_den,
    output logic                o_quot_invalid
);

    localparam int PW = 2 * IN_WIDTH;

    logic [IN_WIDTH-1:0] r_na, r_da, r_nb, r_db, r_ma, r_mb;
    logic [SUM_W-1:0]    r_p, r_gx;
    logic [OUT_W-1:0]    r_q, r_gy;
    logic [OUT_W-1:0]    r_sa, r_sb, r_lcm, r_sd, r_qn, r_qd;
    logic [SUM_W-1:0]    r_sn;
    logic                r_inv;

    logic [PW-1:0]       w_pa, w_pb, w_pl;
    logic                w_start;
    logic [SUM_W-1:0]    w_dividend;
    logic [OUT_W-1:0]    w_divisor;
    logic [SUM_W-1:0]    w_quo;
    logic [OUT_W-1:0]    w_rem;
    logic                w_done;

    assign w_pa = r_na * r_ma;
    assign w_pb = r_nb * r_mb;
    assign w_pl = r_da * r_ma;

    assign w_start = (i_cmd.op == OP_GCD_GO) || (i_cmd.op == OP_P_GO) ||
                     (i_cmd.op == OP_Q_GO);

    always_comb begin
        w_dividend = r_gx;
        w_divisor  = r_gy;
        unique case (i_cmd.op)
            OP_P_GO: begin
                w_dividend = r_p;
                w_divisor  = r_gx[OUT_W-1:0];
            end
            OP_Q_GO: begin
                w_dividend = {1'b0, r_q};
                w_divisor  = r_gx[OUT_W-1:0];
            end
            default: begin
                w_dividend = r_gx;
                w_divisor  = r_gy;
            end
        endcase
    end

    fcds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quo      (w_quo),
        .o_rem      (w_rem),
        .o_done     (w_done)
    );

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_na <= i_num_a;
                r_da <= (i_den_a == '0) ? IN_WIDTH'(1) : i_den_a;
                r_nb <= i_num_b;
                r_db <= (i_den_b == '0) ? IN_WIDTH'(1) : i_den_b;
            end
            // operands of each gcd reduction also seed the euclid pair
            OP_JOB: begin
                unique case (i_cmd.job)
                    J_A: begin
                        r_p  <= SUM_W'(r_na);
                        r_q  <= OUT_W'(r_da);
                        r_gx <= SUM_W'(r_na);
                        r_gy <= OUT_W'(r_da);
                    end
                    J_B: begin
                        r_p  <= SUM_W'(r_nb);
                        r_q  <= OUT_W'(r_db);
                        r_gx <= SUM_W'(r_nb);
                        r_gy <= OUT_W'(r_db);
                    end
                    J_L: begin
                        r_p  <= SUM_W'(r_da);
                        r_q  <= OUT_W'(r_db);
                        r_gx <= SUM_W'(r_da);
                        r_gy <= OUT_W'(r_db);
                    end
                    J_S: begin
                        r_p  <= {1'b0, r_sa} + {1'b0, r_sb};
                        r_q  <= r_lcm;
                        r_gx <= {1'b0, r_sa} + {1'b0, r_sb};
                        r_gy <= r_lcm;
                    end
                    default: begin
                        r_p  <= {1'b0, r_sa};
                        r_q  <= r_sb;
                        r_gx <= {1'b0, r_sa};
                        r_gy <= r_sb;
                    end
                endcase
            end
            OP_GCD_WAIT: begin
                if (w_done) begin
                    r_gx <= {1'b0, r_gy};
                    r_gy <= w_rem;
                end
            end
            OP_P_WAIT: begin
                if (w_done) r_p <= w_quo;
            end
            OP_Q_WAIT: begin
                if (w_done) r_q <= w_quo[OUT_W-1:0];
            end
            OP_WRITE: begin
                r_gx <= '0;
                r_gy <= '0;
                unique case (i_cmd.job)
                    J_A: begin
                        r_na <= r_p[IN_WIDTH-1:0];
                        r_da <= r_q[IN_WIDTH-1:0];
                    end
                    J_B: begin
                        r_nb <= r_p[IN_WIDTH-1:0];
                        r_db <= r_q[IN_WIDTH-1:0];
                    end
                    J_L: begin
                        r_mb <= r_p[IN_WIDTH-1:0];
                        r_ma <= r_q[IN_WIDTH-1:0];
                    end
                    J_S: begin
                        r_sn  <= r_p;
                        r_sd  <= r_q;
                        r_inv <= (r_sb == '0);
                        r_qn  <= '0;
                        r_qd  <= '0;
                    end
                    default: begin
                        r_qn <= r_p[OUT_W-1:0];
                        r_qd <= r_q;
                    end
                endcase
            end
            OP_MUL: begin
                r_sa  <= OUT_W'(w_pa);
                r_sb  <= OUT_W'(w_pb);
                r_lcm <= OUT_W'(w_pl);
            end
            default: begin
                if (!i_rst_n) begin
                    r_gx <= '0;
                    r_gy <= '0;
                end
            end
        endcase
    end

    assign o_sts.div_done = w_done;
    assign o_sts.gy_zero  = (r_gy == '0);
    assign o_sts.sb_zero  = (r_sb == '0);

    assign o_scaled_num_a = r_sa;
    assign o_scaled_num_b = r_sb;
    assign o_common_den   = r_lcm;
    assign o_sum_num      = r_sn;
    assign o_sum_den      = r_sd;
    assign o_quot_num     = r_qn;
    assign o_quot_den     = r_qd;
    assign o_quot_invalid = r_inv;

endmodule

### hdl/fcds_ctrl.sv
// ----------------------------------------------------------------------------
// fcds_ctrl
// sequencer for the reductions, scaling and result hand-off
// ----------------------------------------------------------------------------
module fcds_ctrl
    import fcds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state, n_state;
    t_job   r_job, n_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= J_A;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        o_cmd.op   = OP_NONE;
        o_cmd.job  = r_job;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_job    = J_A;
                    n_state  = S_JOB;
                end
            end
            S_JOB: begin
                o_cmd.op = OP_JOB;
                n_state  = S_GCD_GO;
            end
            S_GCD_GO: begin
                o_cmd.op = OP_GCD_GO;
                n_state  = S_GCD_WAIT;
            end
            S_GCD_WAIT: begin
                o_cmd.op = OP_GCD_WAIT;
                if (i_sts.div_done) n_state = S_GCD_CHK;
            end
            S_GCD_CHK: begin
                n_state = i_sts.gy_zero ? S_P_GO : S_GCD_GO;
            end
            S_P_GO: begin
                o_cmd.op = OP_P_GO;
                n_state  = S_P_WAIT;
            end
            S_P_WAIT: begin
                o_cmd.op = OP_P_WAIT;
                if (i_sts.div_done) n_state = S_Q_GO;
            end
            S_Q_GO: begin
                o_cmd.op = OP_Q_GO;
                n_state  = S_Q_WAIT;
            end
            S_Q_WAIT: begin
                o_cmd.op = OP_Q_WAIT;
                if (i_sts.div_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.op = OP_WRITE;
                unique case (r_job)
                    J_A: begin
                        n_job   = J_B;
                        n_state = S_JOB;
                    end
                    J_B: begin
                        n_job   = J_L;
                        n_state = S_JOB;
                    end
                    J_L: n_state = S_MUL;
                    J_S: begin
                        // zero second numerator skips the quotient
                        n_job   = J_Q;
                        n_state = i_sts.sb_zero ? S_OUT : S_JOB;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_job    = J_S;
                n_state  = S_JOB;
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

### hdl/fraction_common_den_sum_quotient.sv
// ----------------------------------------------------------------------------
// fraction_common_den_sum_quotient
// reduces two fractions, scales them to their lcm, gives reduced sum and
// quotient
//
// channel  direction  handshake                      payload
// input    in         i_in_valid / o_in_stall        num_a den_a num_b den_b
// output   out        o_out_valid / i_out_stall      eight result fields
//
// one transaction at a time; Euclid steps and divisions share one bit-serial
// divider: each reduction runs its Euclid steps and then two divisions, and a
// transaction runs four reductions (five when the second numerator is nonzero).
// reset clears the sequencer, the divider control and, if no load is issued,
// the Euclid pair, not operands or results. the result is held until the
// output side takes it, and no input is taken until then.
// ----------------------------------------------------------------------------
module fraction_common_den_sum_quotient
    import fcds_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [IN_WIDTH-1:0] i_num_a,
    input  logic [IN_WIDTH-1:0] i_den_a,
    input  logic [IN_WIDTH-1:0] i_num_b,
    input  logic [IN_WIDTH-1:0] i_den_b,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [OUT_W-1:0]    o_scaled_num_a,
    output logic [OUT_W-1:0]    o_scaled_num_b,
    output logic [OUT_W-1:0]    o_common_den,
    output logic [SUM_W-1:0]    o_sum_num,
    output logic [OUT_W-1:0]    o_sum_den,
    output logic [OUT_W-1:0]    o_quot_num,
    output logic [OUT_W-1:0]    o_quot_den,
    output logic                o_quot_invalid
);

    t_cmd w_cmd;
    t_sts w_sts;

    fcds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    fcds_dp #(.IN_WIDTH(IN_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_num_a        (i_num_a),
        .i_den_a        (i_den_a),
        .i_num_b        (i_num_b),
        .i_den_b        (i_den_b),
        .o_scaled_num_a (o_scaled_num_a),
        .o_scaled_num_b (o_scaled_num_b),
        .o_common_den   (o_common_den),
        .o_sum_num      (o_sum_num),
        .o_sum_den      (o_sum_den),
        .o_quot_num     (o_quot_num),
        .o_quot_den     (o_quot_den),
        .o_quot_invalid (o_quot_invalid)
    );

endmodule

### hdl/fcds_chk.sv
// ----------------------------------------------------------------------------
// fcds_chk
// port-level checks for the fraction unit
// ----------------------------------------------------------------------------
module fcds_chk
    import fcds_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [OUT_W-1:0]   o_common_den,
    input logic [OUT_W-1:0]   o_sum_den,
    input logic [OUT_W-1:0]   o_quot_num,
    input logic [OUT_W-1:0]   o_quot_den,
    input logic               o_quot_invalid
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sum_den))
        else $error("result dropped while stalled");

    // only one transaction in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    a_no_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("result too early");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_quot_invalid |-> o_quot_num == '0 && o_quot_den == '0)
        else $error("invalid quotient not zeroed");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_common_den != '0 && o_sum_den != '0)
        else $error("zero denominator on output");

endmodule

bind fraction_common_den_sum_quotient fcds_chk u_fcds_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_common_den   (o_common_den),
    .o_sum_den      (o_sum_den),
    .o_quot_num     (o_quot_num),
    .o_quot_den     (o_quot_den),
    .o_quot_invalid (o_quot_invalid)
);
